// ----- design/kpsd_pkg.sv -----
package kpsd_pkg;

    localparam int ColW      = 3;
    localparam int RowW      = 2;
    localparam int RowDriveW = 4;
    localparam int KeyW      = 5;
    localparam int KeyOutW   = 4;
    localparam int EventW    = 2;
    localparam int DbW       = 8;
    localparam int HoldW     = 16;
    localparam int CfgDataW  = 16;
    localparam int CfgAddrW  = 1;
    localparam int InDataW   = 8;
    localparam int OutDataW  = 16;

    localparam logic [DbW-1:0]      DEBOUNCE_RESET = 8'd64;
    localparam logic [HoldW-1:0]    LONG_RESET     = 16'd6000;
    localparam logic [KeyW-1:0]     NO_KEY         = 5'd20;
    localparam logic [KeyW-1:0]     HASH_KEY       = 5'd11;

    localparam logic [CfgAddrW-1:0] REG_DEBOUNCE   = 1'd0;
    localparam logic [CfgAddrW-1:0] REG_LONG_PRESS = 1'd1;

    localparam logic [EventW-1:0]   EV_NONE        = 2'd0;
    localparam logic [EventW-1:0]   EV_LIGHT       = 2'd1;
    localparam logic [EventW-1:0]   EV_SHORT_HASH  = 2'd2;
    localparam logic [EventW-1:0]   EV_LONG_HASH   = 2'd3;

    typedef struct packed {
        logic [DbW-1:0]   debounce_ticks;
        logic [HoldW-1:0] long_press_ticks;
    } kpsd_cfg_t;

    typedef struct packed {
        logic [KeyOutW-1:0]   key_value;
        logic [EventW-1:0]    event_code;
        logic [RowDriveW-1:0] row_drive;
    } kpsd_result_t;

endpackage

// ----- design/kpsd_cfg_regs.sv -----
module kpsd_cfg_regs
    import kpsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output kpsd_cfg_t           cfg
);

    kpsd_cfg_t cfg_reg;
    kpsd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DEBOUNCE:   cfg_next.debounce_ticks   = cfg_wdata[DbW-1:0];
                REG_LONG_PRESS: cfg_next.long_press_ticks = cfg_wdata[HoldW-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= LONG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/kpsd_fsm.sv -----
module kpsd_fsm
    import kpsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [ColW-1:0]  column_levels,
    input  logic             tick,
    input  kpsd_cfg_t        cfg,
    output kpsd_result_t     result
);

    localparam logic [2:0] ST_SCAN       = 3'd0;
    localparam logic [2:0] ST_PRESS_DB   = 3'd1;
    localparam logic [2:0] ST_HELD       = 3'd2;
    localparam logic [2:0] ST_RELEASE_DB = 3'd3;
    localparam logic [2:0] ST_EMIT       = 3'd4;

    logic [2:0]       state_reg,   state_next;
    logic [RowW-1:0]  row_reg,     row_next;
    logic [KeyW-1:0]  key_reg,     key_next;
    logic [DbW-1:0]   db_cnt_reg,  db_cnt_next;
    logic [HoldW-1:0] hold_cnt_reg, hold_cnt_next;
    logic [HoldW-1:0] hold_len_reg, hold_len_next;

    logic            any_col;
    logic [KeyW-1:0] decoded;
    logic [DbW-1:0]   db_inc;
    logic [HoldW-1:0] hold_inc;
    logic             db_done;

    // lowest active column wins
    function automatic logic [KeyW-1:0] decode_key(input logic [RowW-1:0] row,
                                                   input logic [ColW-1:0] cols);
        logic [KeyW-1:0] k;
        k = NO_KEY;
        if (cols[0])
        begin
            unique case (row)
                2'd0:    k = 5'd1;
                2'd1:    k = 5'd4;
                2'd2:    k = 5'd7;
                default: k = 5'd10;
            endcase
        end
        else if (cols[1])
        begin
            unique case (row)
                2'd0:    k = 5'd2;
                2'd1:    k = 5'd5;
                2'd2:    k = 5'd8;
                default: k = 5'd0;
            endcase
        end
        else if (cols[2])
        begin
            unique case (row)
                2'd0:    k = 5'd3;
                2'd1:    k = 5'd6;
                2'd2:    k = 5'd9;
                default: k = HASH_KEY;
            endcase
        end
        return k;
    endfunction

    assign any_col  = |column_levels;
    assign decoded  = decode_key(row_reg, column_levels);
    assign db_inc   = (tick && (db_cnt_reg != {DbW{1'b1}})) ? db_cnt_reg + 1'b1 : db_cnt_reg;
    assign hold_inc = (tick && (hold_cnt_reg != {HoldW{1'b1}})) ?
                      hold_cnt_reg + 1'b1 : hold_cnt_reg;
    assign db_done  = db_inc > cfg.debounce_ticks;

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        key_next      = key_reg;
        db_cnt_next   = db_inc;
        hold_cnt_next = hold_inc;
        hold_len_next = hold_len_reg;
        result.event_code = EV_NONE;
        result.key_value  = '0;

        unique case (state_reg)
            ST_SCAN:
            begin
                key_next      = NO_KEY;
                hold_len_next = '0;
                if (any_col)
                begin
                    key_next    = decoded;
                    db_cnt_next = '0;
                    state_next  = ST_PRESS_DB;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_PRESS_DB:
            begin
                if (db_done)
                begin
                    if (decoded == key_reg)
                    begin
                        hold_cnt_next = '0;
                        state_next    = ST_HELD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_HELD:
            begin
                if (!any_col)
                begin
                    db_cnt_next = '0;
                    state_next  = ST_RELEASE_DB;
                end
            end
            ST_RELEASE_DB:
            begin
                if (db_done)
                begin
                    if (!any_col && (decoded != key_reg))
                    begin
                        hold_len_next = hold_inc;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_HELD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (key_reg <= 5'd10)
                begin
                    result.event_code = EV_LIGHT;
                    result.key_value  = key_reg[KeyOutW-1:0];
                end
                else if (key_reg == HASH_KEY)
                begin
                    result.event_code = (hold_len_reg < cfg.long_press_ticks) ?
                                        EV_SHORT_HASH : EV_LONG_HASH;
                    result.key_value  = HASH_KEY[KeyOutW-1:0];
                end
                state_next = ST_SCAN;
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase

        result.row_drive = RowDriveW'(1) << row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SCAN;
            row_reg      <= '0;
            key_reg      <= NO_KEY;
            db_cnt_reg   <= '0;
            hold_cnt_reg <= '0;
            hold_len_reg <= '0;
        end
        else if (step_en)
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            key_reg      <= key_next;
            db_cnt_reg   <= db_cnt_next;
            hold_cnt_reg <= hold_cnt_next;
            hold_len_reg <= hold_len_next;
        end
    end

endmodule

// ----- design/keypad_scan_debounce_press_timer.sv -----
// channel   dir  width  contents
// s_axis    in   8      scan step word
// m_axis    out  16     result word, one per scan step
// cfg       in   1+16   register write, index 0 debounce, 1 long press
//
// One word per cycle unless the output stalls; stages: input register, result register.
// Scan state advances only when a word moves from input to result register.
// A stalled output holds the result; the input register still takes a word while empty.
// Reset clears scan state and loads the default register values.
module keypad_scan_debounce_press_timer
    import kpsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // [2:0] column_levels, [3] tick, [7:4] zero
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // [3:0] row_drive, [5:4] event_code,
                                                // [9:6] key_value, [15:10] zero
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    kpsd_cfg_t    cfg;
    kpsd_result_t step_result;

    logic            in_valid_reg;
    logic [ColW-1:0] cols_reg;
    logic            tick_reg;
    logic            out_valid_reg;
    kpsd_result_t    out_reg;
    logic            advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    kpsd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kpsd_fsm u_fsm
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .column_levels (cols_reg),
        .tick          (tick_reg),
        .cfg           (cfg),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            cols_reg <= s_axis_tdata[ColW-1:0];
            tick_reg <= s_axis_tdata[ColW];
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OutDataW - $bits(kpsd_result_t)){1'b0}}, out_reg};

endmodule
